// ===== design/hds_pkg.sv =====
// hds_pkg: shared types, constants and helper functions for the hemisphere sampler
// no dependencies
`timescale 1ns / 1ps

package hds_pkg;

    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 24;
    // input register, two root chains, z select, square, cordic chain, product, output
    localparam int LAT = 2 * SQRT_STEPS + CORDIC_STEPS + 5;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    typedef enum logic [1:0] {
        MODE_UNIFORM = 2'd0,
        MODE_COSINE  = 2'd1,
        MODE_CONE    = 2'd2,
        MODE_SPARE   = 2'd3
    } t_mode;

    typedef enum logic [7:0] {
        REG_SAMPLE_MODE  = 8'd0,
        REG_CONE_COS_MAX = 8'd1
    } t_reg_idx;

    typedef struct packed {
        logic [61:0] rem;
        logic [61:0] root;
        logic [63:0] tag;
    } t_sqrt_lane;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] ang;
        logic        [63:0] tag;
    } t_cordic_lane;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [32:0] atan_turn(input logic [4:0] i);
        logic signed [32:0] v;
        case (i)
            5'd0:  v = 33'sh020000000;
            5'd1:  v = 33'sh012E4051E;
            5'd2:  v = 33'sh009FB385B;
            5'd3:  v = 33'sh0051111D4;
            5'd4:  v = 33'sh0028B0D43;
            5'd5:  v = 33'sh00145D7E1;
            5'd6:  v = 33'sh000A2F61E;
            5'd7:  v = 33'sh000517C55;
            5'd8:  v = 33'sh00028BE53;
            5'd9:  v = 33'sh000145F2F;
            5'd10: v = 33'sh0000A2F98;
            5'd11: v = 33'sh0000517CC;
            5'd12: v = 33'sh000028BE6;
            5'd13: v = 33'sh0000145F3;
            5'd14: v = 33'sh00000A2FA;
            5'd15: v = 33'sh00000517D;
            5'd16: v = 33'sh0000028BE;
            5'd17: v = 33'sh00000145F;
            5'd18: v = 33'sh000000A30;
            5'd19: v = 33'sh000000518;
            5'd20: v = 33'sh00000028C;
            5'd21: v = 33'sh000000146;
            5'd22: v = 33'sh0000000A3;
            5'd23: v = 33'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round Q.60 product to Q1.15 and saturate
    function automatic logic signed [15:0] round_sat16(input logic signed [63:0] p);
        logic signed [63:0] v;
        v = (p + 64'sd17592186044416) >>> 45;
        if (v > 64'sd32767) begin
            return 16'sd32767;
        end else if (v < -64'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

endpackage

// ===== design/hds_in_if.sv =====
// hds_in_if: input channel carrying one random pair per transaction
// no dependencies
`timescale 1ns / 1ps

interface hds_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] rand_azimuth;
    logic [15:0] rand_polar;

    modport source (output valid, output rand_azimuth, output rand_polar, input ready);
    modport sink   (input valid, input rand_azimuth, input rand_polar, output ready);
endinterface

// ===== design/hds_out_if.sv =====
// hds_out_if: output channel carrying one direction per transaction
// no dependencies
`timescale 1ns / 1ps

interface hds_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic        [14:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ===== design/hds_cfg_if.sv =====
// hds_cfg_if: register write channel
// no dependencies
`timescale 1ns / 1ps

interface hds_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/hds_sqrt_cell.sv =====
// hds_sqrt_cell: one digit of a bit-by-bit integer square root, registered
// depends on hds_pkg
`timescale 1ns / 1ps

module hds_sqrt_cell
    import hds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [4:0] i_step,
    input  t_sqrt_lane i_lane,
    output t_sqrt_lane o_lane
);

    t_sqrt_lane  n_lane;
    t_sqrt_lane  r_lane;
    logic [61:0] w_bit;
    logic [61:0] w_trial;

    always_comb begin
        w_bit   = 62'd1 << {i_step, 1'b0};
        w_trial = i_lane.root + w_bit;
        n_lane  = i_lane;
        if (i_lane.rem >= w_trial) begin
            n_lane.rem  = i_lane.rem - w_trial;
            n_lane.root = (i_lane.root >> 1) + w_bit;
        end else begin
            n_lane.root = i_lane.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ===== design/hds_cordic_cell.sv =====
// hds_cordic_cell: one rotation-mode cordic iteration, registered
// depends on hds_pkg
`timescale 1ns / 1ps

module hds_cordic_cell
    import hds_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [4:0]   i_step,
    input  t_cordic_lane i_lane,
    output t_cordic_lane o_lane
);

    t_cordic_lane       n_lane;
    t_cordic_lane       r_lane;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic signed [32:0] w_atan;

    always_comb begin
        w_dx   = i_lane.y >>> i_step;
        w_dy   = i_lane.x >>> i_step;
        w_atan = atan_turn(i_step);
        n_lane = i_lane;
        if (!i_lane.ang[32]) begin
            n_lane.x   = i_lane.x - w_dx;
            n_lane.y   = i_lane.y + w_dy;
            n_lane.ang = i_lane.ang - w_atan;
        end else begin
            n_lane.x   = i_lane.x + w_dx;
            n_lane.y   = i_lane.y - w_dy;
            n_lane.ang = i_lane.ang + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ===== design/hemisphere_direction_sampler.sv =====
// hemisphere_direction_sampler: top level, random pair to local unit direction
// depends on hds_pkg, hds_in_if, hds_out_if, hds_cfg_if, hds_sqrt_cell, hds_cordic_cell
`timescale 1ns / 1ps

// usage
//   i_in carries a pair of Q0.16 fractions (rand_azimuth, rand_polar), one per
//   transaction; o_out returns one direction (dir_x, dir_y signed Q1.15,
//   dir_z unsigned Q0.15) per input transaction, in order
//   i_cfg writes sample_mode (index 0) and cone_cos_max (index 1); it is always
//   ready; write only while no sample is in flight
//   throughput: one sample per cycle unless the output stalls, set by the row
//   of square-root and cordic cells, each cell retiring one digit or one
//   rotation per cycle; pipeline from input transaction to output valid: input
//   register, 31 cells of the polar square root, z select, z squared, 31 cells
//   of the sine square root, 24 cordic cells, product, rounding register
//   stall: when the output holds a result that is not taken, the whole row
//   freezes and i_in.ready drops in the same cycle; nothing is lost
//   reset: i_rst_n low clears all valid flags and both registers
//   (uniform hemisphere, cone cosine zero)

module hemisphere_direction_sampler
    import hds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hds_in_if.sink    i_in,
    hds_out_if.source o_out,
    hds_cfg_if.sink   i_cfg
);

    // configuration
    t_mode       r_mode;
    logic [14:0] r_cone;
    logic        w_cfg_acc;

    // pipeline control
    logic [LAT-1:0] r_vld;
    logic           w_en;

    // input stage
    logic [16:0] w_one_minus;
    logic [15:0] w_cone_span;
    logic [31:0] w_cone_prod;
    logic [30:0] w_zalt;
    t_sqrt_lane  r_p0;

    // chains
    t_sqrt_lane   w_a [0:SQRT_STEPS];
    t_sqrt_lane   w_b [0:SQRT_STEPS];
    t_cordic_lane w_c [0:CORDIC_STEPS];

    // z select and square
    logic [30:0] r_zq;
    logic [15:0] r_zr1;
    logic [60:0] r_d;
    logic [30:0] r_dzq;
    logic [15:0] r_dr1;

    // product and output
    logic signed [32:0] w_cos;
    logic signed [32:0] w_sin;
    logic signed [31:0] w_s;
    logic signed [63:0] r_px;
    logic signed [63:0] r_py;
    logic        [30:0] r_pz;
    logic        [16:0] w_zo;
    logic signed [15:0] r_ox;
    logic signed [15:0] r_oy;
    logic        [14:0] r_oz;

    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UNIFORM;
            r_cone <= '0;
        end else if (w_cfg_acc) begin
            case (i_cfg.index)
                REG_SAMPLE_MODE:  r_mode <= t_mode'(i_cfg.data[1:0]);
                REG_CONE_COS_MAX: r_cone <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // whole row advances unless a finished result is held
    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // z for uniform and cone modes, 1 - r2 for the cosine root
    always_comb begin
        w_one_minus = 17'd65536 - {1'b0, i_in.rand_polar};
        w_cone_span = 16'd32768 - {1'b0, r_cone};
        w_cone_prod = w_cone_span * i_in.rand_polar;
        if (r_mode == MODE_CONE) begin
            w_zalt = 31'h4000_0000 - 31'(w_cone_prod[31:1]);
        end else begin
            w_zalt = {w_one_minus, 14'd0};
        end
    end

    // tag: [47] cosine mode, [46:16] alternate z, [15:0] azimuth
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0.rem  <= {1'b0, w_one_minus, 44'd0};
            r_p0.root <= '0;
            r_p0.tag  <= {16'd0, (r_mode == MODE_COSINE), w_zalt, i_in.rand_azimuth};
        end
    end

    assign w_a[0] = r_p0;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_polar_root
        hds_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (5'(SQRT_STEPS - 1 - g)),
            .i_lane (w_a[g]),
            .o_lane (w_a[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zq  <= w_a[SQRT_STEPS].tag[47] ? w_a[SQRT_STEPS].root[30:0]
                                              : w_a[SQRT_STEPS].tag[46:16];
            r_zr1 <= w_a[SQRT_STEPS].tag[15:0];
            r_d   <= 61'h1000_0000_0000_0000 - 61'(r_zq * r_zq);
            r_dzq <= r_zq;
            r_dr1 <= r_zr1;
        end
    end

    assign w_b[0] = '{rem: 62'(r_d), root: '0, tag: {17'd0, r_dzq, r_dr1}};

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sine_root
        hds_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (5'(SQRT_STEPS - 1 - g)),
            .i_lane (w_b[g]),
            .o_lane (w_b[g+1])
        );
    end

    // cordic tag: [63:62] quadrant, [61:31] sine theta, [30:0] z
    assign w_c[0] = '{x:   CORDIC_GAIN,
                      y:   '0,
                      ang: 33'({w_b[SQRT_STEPS].tag[13:0], 16'd0}),
                      tag: {w_b[SQRT_STEPS].tag[15:14], w_b[SQRT_STEPS].root[30:0],
                            w_b[SQRT_STEPS].tag[46:16]}};

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rotate
        hds_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (5'(g)),
            .i_lane (w_c[g]),
            .o_lane (w_c[g+1])
        );
    end

    // quadrant fold of the first-quadrant rotation
    always_comb begin
        case (w_c[CORDIC_STEPS].tag[63:62])
            2'd0: begin
                w_cos = w_c[CORDIC_STEPS].x;
                w_sin = w_c[CORDIC_STEPS].y;
            end
            2'd1: begin
                w_cos = -w_c[CORDIC_STEPS].y;
                w_sin = w_c[CORDIC_STEPS].x;
            end
            2'd2: begin
                w_cos = -w_c[CORDIC_STEPS].x;
                w_sin = -w_c[CORDIC_STEPS].y;
            end
            default: begin
                w_cos = w_c[CORDIC_STEPS].y;
                w_sin = -w_c[CORDIC_STEPS].x;
            end
        endcase
        w_s  = $signed({1'b0, w_c[CORDIC_STEPS].tag[61:31]});
        w_zo = 17'(({1'b0, r_pz} + 32'd16384) >> 15);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= 64'(w_s * w_cos);
            r_py <= 64'(w_s * w_sin);
            r_pz <= w_c[CORDIC_STEPS].tag[30:0];
            r_ox <= round_sat16(r_px);
            r_oy <= round_sat16(r_py);
            r_oz <= (w_zo > 17'd32767) ? 15'd32767 : w_zo[14:0];
        end
    end

    assign o_out.valid = r_vld[LAT-1];
    assign o_out.dir_x = r_ox;
    assign o_out.dir_y = r_oy;
    assign o_out.dir_z = r_oz;

`ifndef NO_ASSERTIONS
    // a held result must block new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input accepted while output stalled");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // configuration registers move only on a write
    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cfg_acc |=> $stable(r_mode) && $stable(r_cone))
        else $error("configuration changed without a write");

    // polar cosine never exceeds one
    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SQRT_STEPS + 1] |-> r_zq <= 31'h4000_0000)
        else $error("polar cosine out of range");
`endif

endmodule
